[sv/bchc_pkg.sv]
// Shared types and constants for the button click/hold classifier.
package bchc_pkg;

  localparam int NUM_KEYS_DEF   = 16;
  localparam int TIMER_BITS_DEF = 24;

  // Countdown to the next repeat: loaded with a 16-bit delay, can dip one delta below zero
  localparam int REP_W  = 18;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;
  localparam int KEYO_W = 4;
  localparam int CNT_W  = 8;

  localparam logic [CFG_W-1:0] CLICK_THR_RST    = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_THR_RST     = 16'd500;
  localparam logic [CFG_W-1:0] FIRST_DELAY_RST  = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_PER_RST   = 16'd100;
  localparam logic [CFG_W-1:0] INTERVAL_THR_RST = 16'd250;

  localparam logic [CIDX_W-1:0] CFG_CLICK_THR    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_HOLD_THR     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_FIRST_DELAY  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_REPEAT_PER   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_INTERVAL_THR = 3'd4;

  typedef enum logic [1:0] {
    EV_CLICK      = 2'd0,
    EV_MULTI      = 2'd1,
    EV_HOLD_START = 2'd2,
    EV_REPEAT     = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    PH_RELEASED = 3'd0,
    PH_PREPRESS = 3'd1,
    PH_PRELONG  = 3'd2,
    PH_LONGHOLD = 3'd3,
    PH_MULTI    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [KEYO_W-1:0] key;
    ev_kind_t          kind;
    logic [CNT_W-1:0]  cnt;
  } ev_t;

endpackage

[sv/button_click_hold_classifier_unit.sv]
// Scan: an accepted tick walks the keys one per cycle unless a stalled output holds a key, then flushes.
// Events leave in key order; each appears once the next event (or the end of the scan) is known.
// Ticks: a new tick is taken only after the scan and flush (in_stall is high until then); the single
// shared key unit and the one-deep pending event slot set this, and a stalled output pauses the scan.
// Reset (synchronous, rst_n low): every key released with cleared timers and count,
// registers back to their defaults, no event pending.
module button_click_hold_classifier_unit #(
  parameter int NUM_KEYS   = bchc_pkg::NUM_KEYS_DEF,
  parameter int TIMER_BITS = bchc_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bchc_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [bchc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     in_delta_ms,
  input  logic [15:0]                     in_key_levels,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bchc_pkg::KEYO_W-1:0]     out_key_index,
  output logic [1:0]                      out_event_kind,
  output logic [bchc_pkg::CNT_W-1:0]      out_click_count,
  output logic                            out_last_event
);
  import bchc_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } seq_t;

  seq_t seq_r;

  logic [CFG_W-1:0] click_thr_r, hold_thr_r, first_delay_r, repeat_per_r, interval_thr_r;
  logic [15:0]      delta_r, levels_r;
  logic [KW-1:0]    key_cnt_r;

  phase_t                   ph_r    [NUM_KEYS];
  logic [TIMER_BITS-1:0]    press_r [NUM_KEYS];
  logic [TIMER_BITS-1:0]    gap_r   [NUM_KEYS];
  logic signed [REP_W-1:0]  rep_r   [NUM_KEYS];
  logic [CNT_W-1:0]         cc_r    [NUM_KEYS];

  logic pend_v_r;
  ev_t  pend_r;
  logic out_valid_r;
  ev_t  out_r;
  logic out_last_r;

  // Shared key unit
  phase_t                  ph_cur, ph_nxt;
  logic [TIMER_BITS-1:0]   press_nxt, gap_nxt;
  logic signed [REP_W-1:0] rep_cur, rep_nxt;
  logic [CNT_W-1:0]        cc_cur, cc_nxt;
  logic [6:0]              key_ext;
  logic                    pressed;
  logic [TIMER_BITS:0]     press_sum, gap_sum;
  logic                    ev_hit;
  ev_t                     ev_new;
  logic                    out_free, step_ok, out_load;

  always_comb begin
    ph_cur    = ph_r[key_cnt_r];
    rep_cur   = rep_r[key_cnt_r];
    cc_cur    = cc_r[key_cnt_r];
    key_ext   = 7'(key_cnt_r);
    pressed   = (key_ext < 7'd16) && levels_r[key_ext[3:0]];
    press_sum = {1'b0, press_r[key_cnt_r]} + (TIMER_BITS+1)'(delta_r);
    gap_sum   = {1'b0, gap_r[key_cnt_r]} + (TIMER_BITS+1)'(delta_r);
    press_nxt = !pressed ? '0 :
                (press_sum[TIMER_BITS] ? TIMER_MAX : press_sum[TIMER_BITS-1:0]);
    gap_nxt   = (ph_cur != PH_MULTI) ? '0 :
                (gap_sum[TIMER_BITS] ? TIMER_MAX : gap_sum[TIMER_BITS-1:0]);

    ph_nxt      = ph_cur;
    rep_nxt     = rep_cur;
    cc_nxt      = cc_cur;
    ev_hit      = 1'b0;
    ev_new.key  = KEYO_W'(key_cnt_r);
    ev_new.kind = EV_CLICK;
    ev_new.cnt  = '0;

    unique case (ph_cur)
      PH_PREPRESS: begin
        if (!pressed) begin
          ph_nxt = PH_RELEASED;
        end else if (press_nxt >= TIMER_BITS'(click_thr_r)) begin
          ph_nxt = PH_PRELONG;
        end
      end
      PH_PRELONG: begin
        if (!pressed) begin
          ph_nxt = PH_MULTI;
          if (cc_cur != '1) begin
            cc_nxt = cc_cur + CNT_W'(1);
          end
        end else if (press_nxt >= TIMER_BITS'(hold_thr_r)) begin
          ph_nxt      = PH_LONGHOLD;
          rep_nxt     = $signed(REP_W'(first_delay_r));
          ev_hit      = 1'b1;
          ev_new.kind = EV_HOLD_START;
        end
      end
      PH_LONGHOLD: begin
        if (!rep_cur[REP_W-1] && (rep_cur != '0)) begin
          rep_nxt = rep_cur - $signed(REP_W'(delta_r));
        end else begin
          rep_nxt     = $signed(REP_W'(repeat_per_r));
          ev_hit      = 1'b1;
          ev_new.kind = EV_REPEAT;
        end
        if (!pressed) begin
          ph_nxt = PH_RELEASED;
        end
      end
      PH_MULTI: begin
        if (gap_nxt >= TIMER_BITS'(interval_thr_r)) begin
          if (cc_cur > CNT_W'(1)) begin
            ev_hit      = 1'b1;
            ev_new.kind = EV_MULTI;
            ev_new.cnt  = cc_cur;
          end else if (cc_cur == CNT_W'(1)) begin
            ev_hit      = 1'b1;
            ev_new.kind = EV_CLICK;
            ev_new.cnt  = cc_cur;
          end
          ph_nxt = PH_RELEASED;
        end else if (press_nxt >= TIMER_BITS'(click_thr_r)) begin
          ph_nxt = PH_PRELONG;
        end
      end
      default: begin
        cc_nxt = '0;
        ph_nxt = pressed ? PH_PREPRESS : PH_RELEASED;
      end
    endcase

    out_free = !out_valid_r || !out_stall;
    // Hold the key when a second event needs the output slot and it is still full
    step_ok  = !(ev_hit && pend_v_r && !out_free);
    out_load = ((seq_r == ST_SCAN) && step_ok && ev_hit && pend_v_r) ||
               ((seq_r == ST_FLUSH) && pend_v_r && out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r          <= ST_IDLE;
      key_cnt_r      <= '0;
      pend_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      click_thr_r    <= CLICK_THR_RST;
      hold_thr_r     <= HOLD_THR_RST;
      first_delay_r  <= FIRST_DELAY_RST;
      repeat_per_r   <= REPEAT_PER_RST;
      interval_thr_r <= INTERVAL_THR_RST;
      for (int i = 0; i < NUM_KEYS; i++) begin
        ph_r[i]    <= PH_RELEASED;
        press_r[i] <= '0;
        gap_r[i]   <= '0;
        rep_r[i]   <= '0;
        cc_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLICK_THR:    click_thr_r    <= cfg_data;
          CFG_HOLD_THR:     hold_thr_r     <= cfg_data;
          CFG_FIRST_DELAY:  first_delay_r  <= cfg_data;
          CFG_REPEAT_PER:   repeat_per_r   <= cfg_data;
          CFG_INTERVAL_THR: interval_thr_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (seq_r)
        ST_IDLE: begin
          if (in_valid) begin
            delta_r   <= in_delta_ms;
            levels_r  <= in_key_levels;
            key_cnt_r <= '0;
            seq_r     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step_ok) begin
            ph_r[key_cnt_r]    <= ph_nxt;
            press_r[key_cnt_r] <= press_nxt;
            gap_r[key_cnt_r]   <= gap_nxt;
            rep_r[key_cnt_r]   <= rep_nxt;
            cc_r[key_cnt_r]    <= cc_nxt;
            if (ev_hit) begin
              // Advance the pending event to the output; it is not the last beat
              if (pend_v_r) begin
                out_r      <= pend_r;
                out_last_r <= 1'b0;
              end
              pend_v_r <= 1'b1;
              pend_r   <= ev_new;
            end
            if (key_cnt_r == LAST_KEY) begin
              seq_r <= ST_FLUSH;
            end else begin
              key_cnt_r <= key_cnt_r + KW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_r) begin
            seq_r <= ST_IDLE;
          end else if (out_free) begin
            out_r      <= pend_r;
            out_last_r <= 1'b1;
            pend_v_r   <= 1'b0;
            seq_r      <= ST_IDLE;
          end
        end
        default: seq_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall        = (seq_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_key_index   = out_r.key;
  assign out_event_kind  = out_r.kind;
  assign out_click_count = out_r.cnt;
  assign out_last_event  = out_last_r;

endmodule

[sv/bchc_checker.sv]
// Port-level checks for the button click/hold classifier, bound to the top level.
module bchc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bchc_pkg::KEYO_W-1:0] out_key_index,
  input logic [1:0]                  out_event_kind,
  input logic [bchc_pkg::CNT_W-1:0]  out_click_count,
  input logic                        out_last_event
);
  import bchc_pkg::*;

  // A stalled beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_index) &&
    $stable(out_event_kind) && $stable(out_click_count) && $stable(out_last_event))
    else $error("stalled result beat changed");

  a_hold_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_HOLD_START || out_event_kind == EV_REPEAT)
    |-> out_click_count == '0)
    else $error("hold event carries a click count");

  a_click_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_CLICK |-> out_click_count == CNT_W'(1))
    else $error("single click with count other than one");

  a_multi_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_MULTI |-> out_click_count > CNT_W'(1))
    else $error("multi click with count below two");

endmodule

bind button_click_hold_classifier_unit bchc_checker u_bchc_checker (.*);
